@@ hdl/complementary_tilt_filter_assert.svh @@
// Assertion macros shared by the tilt filter modules.
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define CTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tilt filter assertion failed");

// Consequence holds in the cycle after the antecedent.
`define CTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tilt filter assertion failed");

`endif

@@ hdl/ctf_pkg.sv @@
// Types, constants and the arctangent table of the tilt filter.
`default_nettype none
package ctf_pkg;

  typedef struct packed {
    logic [15:0]        elapsed_us;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } ctf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ctf_qstat_t;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned SQRT_BITS = 24;
  localparam int unsigned MUL_STEPS = 4;
  localparam logic signed [16:0] TICK = 17'sd62500;
  localparam logic [55:0] HALF_DIV = 56'd512000000;

  // ceil(2^53 / 15625); exact floor division for dividends below 2^39.
  localparam logic [39:0] RECIP = 40'd576460752304;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ctf_front.sv @@
// Input side: takes items and zeroes the time step of the first sample.
`default_nettype none
module ctf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [95:0]        s_axis_tdata,
  input  wire ctf_pkg::ctf_qstat_t qstat_i,
  output logic                    push_o,
  output ctf_pkg::ctf_item_t      item_o
);

  logic first_q, first_d;

  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_o = ctf_pkg::ctf_item_t'(s_axis_tdata);
    if (first_q) begin
      item_o.elapsed_us = '0;
    end
    first_d = first_q && !push_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ctf_fifo.sv @@
// Short item queue between the input side and the arithmetic engine.
`default_nettype none
`include "complementary_tilt_filter_assert.svh"
module ctf_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ctf_pkg::ctf_item_t item_i,
  input  wire logic               pop_i,
  output ctf_pkg::ctf_item_t      item_o,
  output ctf_pkg::ctf_qstat_t     qstat_o
);

  localparam int unsigned PW = $clog2(ctf_pkg::QDEPTH);

  ctf_pkg::ctf_item_t mem_q [ctf_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign qstat_o.full  = (cnt_q == (PW+1)'(ctf_pkg::QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign item_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `CTF_ASSERT_NOW(a_no_pop_empty, pop_i, !qstat_o.empty)
  `CTF_ASSERT_NOW(a_no_push_full, push_i, !qstat_o.full)

endmodule
`default_nettype wire

@@ hdl/ctf_back.sv @@
// Arithmetic engine: square root, CORDIC, blend and rounding divide per item.
`default_nettype none
`include "complementary_tilt_filter_assert.svh"
module ctf_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctf_pkg::ctf_qstat_t qstat_i,
  input  wire ctf_pkg::ctf_item_t  item_i,
  output logic                     pop_o,
  input  wire logic [14:0]         accel_gain_i,
  input  wire logic [14:0]         gyro_gain_i,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [47:0]              m_axis_tdata
);

  localparam int unsigned NSTEP =
    (CORDIC_STEPS < ctf_pkg::TABLE_LEN) ? CORDIC_STEPS : ctf_pkg::TABLE_LEN;
  localparam logic [39:0] RCP = ctf_pkg::RECIP;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ1   = 4'd1;
  localparam logic [3:0] S_SQ2   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_CINIT = 4'd4;
  localparam logic [3:0] S_CORD  = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_DPREP = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q;
  logic       lane_q;
  logic [4:0] cnt_q;
  ctf_pkg::ctf_item_t item_q;

  logic [31:0] sq_q;
  logic [47:0] rad_q;
  logic [23:0] root_q;
  logic [27:0] srem_q;
  logic signed [27:0] x_q, y_q;
  logic signed [24:0] z_q;
  logic signed [16:0] acc_r_q, acc_p_q;
  logic signed [23:0] est_r_q, est_p_q;
  logic signed [39:0] ir_q, ip_q;
  logic signed [33:0] ar_q, ap_q;
  logic signed [55:0] s_r_q, s_p_q;
  logic        neg_r_q, neg_p_q;
  logic [39:0] dv_r_q, dv_p_q;
  logic [79:0] pr_r_q, pr_p_q;
  logic        out_valid_q;
  logic [47:0] out_data_q;

  // Operand selection: lane 0 is roll, lane 1 is pitch.
  logic signed [15:0] op_a, op_b;
  logic signed [16:0] op_num;
  logic signed [31:0] a_sq, b_sq;
  assign op_a   = lane_q ? item_q.accel_y : item_q.accel_x;
  assign op_b   = item_q.accel_z;
  assign op_num = lane_q ? -17'(item_q.accel_x) : 17'(item_q.accel_y);
  assign a_sq   = op_a * op_a;
  assign b_sq   = op_b * op_b;

  // One square root step: two radicand bits in, one root bit out.
  logic [27:0] s_try, s_trial;
  assign s_try   = {srem_q[25:0], rad_q[47:46]};
  assign s_trial = {2'b00, root_q, 2'b01};

  // One CORDIC vectoring step.
  logic signed [27:0] xs, ys;
  logic signed [24:0] at;
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = $signed({3'b000, ctf_pkg::atan_lut(cnt_q)});

  // Angle rounded to 1/256 degree, half away from zero.
  logic [24:0] z_mag;
  logic signed [16:0] z_rnd;
  assign z_mag = z_q[24] ? (25'd128 - z_q) : (z_q + 25'd128);
  assign z_rnd = z_q[24] ? -17'(z_mag[24:8]) : 17'(z_mag[24:8]);

  // Blend products.
  logic signed [32:0] rdt_r, rdt_p;
  logic signed [39:0] ir_n, ip_n;
  logic signed [33:0] ar_n, ap_n;
  logic signed [55:0] s_r_n, s_p_n, m_r, m_p;
  logic [55:0] t_r_n, t_p_n;
  assign rdt_r = item_q.rate_x * $signed({1'b0, item_q.elapsed_us});
  assign rdt_p = item_q.rate_y * $signed({1'b0, item_q.elapsed_us});
  assign ir_n  = est_r_q * ctf_pkg::TICK + 40'(rdt_r);
  assign ip_n  = est_p_q * ctf_pkg::TICK + 40'(rdt_p);
  assign ar_n  = acc_r_q * ctf_pkg::TICK;
  assign ap_n  = acc_p_q * ctf_pkg::TICK;
  assign s_r_n = ir_q * $signed({1'b0, gyro_gain_i}) + ar_q * $signed({1'b0, accel_gain_i});
  assign s_p_n = ip_q * $signed({1'b0, gyro_gain_i}) + ap_q * $signed({1'b0, accel_gain_i});
  assign m_r   = s_r_q[55] ? -s_r_q : s_r_q;
  assign m_p   = s_p_q[55] ? -s_p_q : s_p_q;
  assign t_r_n = 56'(m_r) + ctf_pkg::HALF_DIV;
  assign t_p_n = 56'(m_p) + ctf_pkg::HALF_DIV;

  // The divisor 62500*16384 equals 65536*15625. The rounded magnitude is shifted
  // down by 16 and multiplied by the reciprocal of 15625, ten reciprocal bits per
  // cycle from the top. The magnitude stays below 2^55, so the shifted value is
  // below 2^39 and the reciprocal product floors exactly.
  logic [9:0]  rchunk;
  logic [49:0] pp_r, pp_p;
  logic [26:0] q_r, q_p;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    rchunk = RCP[39:30];
      2'd1:    rchunk = RCP[29:20];
      2'd2:    rchunk = RCP[19:10];
      default: rchunk = RCP[9:0];
    endcase
  end
  assign pp_r = dv_r_q * rchunk;
  assign pp_p = dv_p_q * rchunk;
  assign q_r  = pr_r_q[79:53];
  assign q_p  = pr_p_q[79:53];

  // Saturation to the 24-bit angle range.
  logic [23:0] sat_r, sat_p;
  always_comb begin
    if (neg_r_q) begin
      sat_r = (q_r >= 27'd8388608) ? 24'h800000 : -q_r[23:0];
    end else begin
      sat_r = (q_r >= 27'd8388607) ? 24'h7FFFFF : q_r[23:0];
    end
    if (neg_p_q) begin
      sat_p = (q_p >= 27'd8388608) ? 24'h800000 : -q_p[23:0];
    end else begin
      sat_p = (q_p >= 27'd8388607) ? 24'h7FFFFF : q_p[23:0];
    end
  end

  assign pop_o         = (state_q == S_IDLE) && !qstat_i.empty && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          item_q <= item_i;
        end
      end
      S_SQ1: sq_q <= a_sq;
      S_SQ2: begin
        rad_q  <= {sq_q + b_sq, 16'h0000};
        root_q <= '0;
        srem_q <= '0;
      end
      S_SQRT: begin
        rad_q <= {rad_q[45:0], 2'b00};
        if (s_try >= s_trial) begin
          srem_q <= s_try - s_trial;
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          srem_q <= s_try;
          root_q <= {root_q[22:0], 1'b0};
        end
      end
      S_CINIT: begin
        x_q <= $signed({4'b0000, root_q});
        y_q <= {{3{op_num[16]}}, op_num, 8'h00};
        z_q <= '0;
      end
      S_CORD: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end else if (y_q < 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end
      end
      S_ROUND: begin
        if (lane_q) begin
          acc_p_q <= z_rnd;
        end else begin
          acc_r_q <= z_rnd;
        end
      end
      S_MUL1: begin
        ir_q <= ir_n;
        ip_q <= ip_n;
        ar_q <= ar_n;
        ap_q <= ap_n;
      end
      S_MUL2: begin
        s_r_q <= s_r_n;
        s_p_q <= s_p_n;
      end
      S_DPREP: begin
        neg_r_q <= s_r_q[55];
        neg_p_q <= s_p_q[55];
        dv_r_q  <= t_r_n[55:16];
        dv_p_q  <= t_p_n[55:16];
        pr_r_q  <= '0;
        pr_p_q  <= '0;
      end
      S_DIV: begin
        pr_r_q <= {pr_r_q[69:0], 10'b0} + 80'(pp_r);
        pr_p_q <= {pr_p_q[69:0], 10'b0} + 80'(pp_p);
      end
      S_DONE: out_data_q <= {sat_p, sat_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane_q      <= 1'b0;
      cnt_q       <= '0;
      est_r_q     <= '0;
      est_p_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            lane_q  <= 1'b0;
            state_q <= S_SQ1;
          end
        end
        S_SQ1: state_q <= S_SQ2;
        S_SQ2: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(ctf_pkg::SQRT_BITS - 1)) begin
            state_q <= S_CINIT;
          end
        end
        S_CINIT: begin
          cnt_q   <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(NSTEP - 1)) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (lane_q) begin
            state_q <= S_MUL1;
          end else begin
            lane_q  <= 1'b1;
            state_q <= S_SQ1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_DPREP;
        S_DPREP: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(ctf_pkg::MUL_STEPS - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          est_r_q     <= $signed(sat_r);
          est_p_q     <= $signed(sat_p);
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CTF_ASSERT_NOW(a_start_with_free_output, pop_o, !out_valid_q)
  `CTF_ASSERT_NEXT(a_done_shows_result, state_q == S_DONE, out_valid_q)
  `CTF_ASSERT_NOW(a_sqrt_count_bound, state_q == S_SQRT, cnt_q < 5'(ctf_pkg::SQRT_BITS))
  `CTF_ASSERT_NOW(a_div_count_bound, state_q == S_DIV, cnt_q < 5'(ctf_pkg::MUL_STEPS))

endmodule
`default_nettype wire

@@ hdl/complementary_tilt_filter.sv @@
// Complementary roll and pitch filter: one result per IMU sample.
// The engine works on one item at a time, paced by the shared square root and CORDIC
// unit (run once per angle) and the four-step reciprocal divide; it takes the next item
// only once the previous result is taken. A four-entry queue takes items while the
// engine works.
// Reset clears the angle estimates, the first-sample flag is set and gains load defaults.
`default_nettype none
module complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_us (16 bits each)
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // roll_angle, pitch_angle (24 bits each)
  output logic [47:0]      m_axis_tdata
);

  localparam logic CFG_ACCEL_GAIN = 1'b0;
  localparam logic CFG_GYRO_GAIN  = 1'b1;

  logic [14:0] accel_gain_q, gyro_gain_q;
  logic        push, pop;
  ctf_pkg::ctf_item_t  in_item, q_item;
  ctf_pkg::ctf_qstat_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= 15'd328;
      gyro_gain_q  <= 15'd16056;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_GAIN: accel_gain_q <= cfg_data_i;
        CFG_GYRO_GAIN:  gyro_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (in_item)
  );

  ctf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .qstat_o (qstat)
  );

  ctf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .item_i        (q_item),
    .pop_o         (pop),
    .accel_gain_i  (accel_gain_q),
    .gyro_gain_i   (gyro_gain_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
